/* hdl/clb_pkg.sv */
// shared types, constants and tables for the console led blink controller
package clb_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int ADDR_W = $clog2(LINE_CAPACITY);
    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
    localparam int MAX_CMD_LEN = 12;
    localparam int NUM_CMDS = 13;

    localparam logic [1:0] CMD_CHAR = 2'd0;
    localparam logic [1:0] CMD_SW1 = 2'd1;
    localparam logic [1:0] CMD_SW2 = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_SP = 8'h20;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_char;
        logic       bad_command;
        logic [3:0] led_pins;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    // request from the line engine to the blink state
    typedef struct packed {
        logic       set_color;
        logic [2:0] color;
        logic       set_rate;
        logic [2:0] rate;
    } t_apply;

    function automatic logic [3:0] pin_of(input logic [2:0] c);
        case (c)
            3'd1: pin_of = 4'h8;
            3'd2: pin_of = 4'h4;
            3'd3: pin_of = 4'hC;
            3'd4: pin_of = 4'h2;
            3'd5: pin_of = 4'hA;
            3'd6: pin_of = 4'h6;
            3'd7: pin_of = 4'hE;
            default: pin_of = 4'h0;
        endcase
    endfunction

    function automatic logic [9:0] period_of(input logic [2:0] r);
        case (r)
            3'd1: period_of = 10'd250;
            3'd2: period_of = 10'd125;
            3'd3: period_of = 10'd62;
            3'd4: period_of = 10'd31;
            3'd5: period_of = 10'd15;
            default: period_of = 10'd1000;
        endcase
    endfunction

    function automatic logic [3:0] cmd_len(input logic [3:0] k);
        case (k)
            4'd0: cmd_len = 4'd10;
            4'd1: cmd_len = 4'd9;
            4'd2: cmd_len = 4'd9;
            4'd3: cmd_len = 4'd8;
            4'd4: cmd_len = 4'd11;
            4'd5: cmd_len = 4'd12;
            4'd6: cmd_len = 4'd10;
            4'd11: cmd_len = 4'd7;
            4'd12: cmd_len = 4'd7;
            default: cmd_len = 4'd6;
        endcase
    endfunction

    // command text, left aligned, char 0 in the top byte
    function automatic logic [95:0] cmd_text(input logic [3:0] k);
        case (k)
            4'd0: cmd_text = {"colorgreen", 16'h0};
            4'd1: cmd_text = {"colorblue", 24'h0};
            4'd2: cmd_text = {"colorcyan", 24'h0};
            4'd3: cmd_text = {"colorred", 32'h0};
            4'd4: cmd_text = {"coloryellow", 8'h0};
            4'd5: cmd_text = "colormagenta";
            4'd6: cmd_text = {"colorwhite", 16'h0};
            4'd7: cmd_text = {"blink1", 48'h0};
            4'd8: cmd_text = {"blink2", 48'h0};
            4'd9: cmd_text = {"blink4", 48'h0};
            4'd10: cmd_text = {"blink8", 48'h0};
            4'd11: cmd_text = {"blink16", 40'h0};
            default: cmd_text = {"blink32", 40'h0};
        endcase
    endfunction

    function automatic logic [2:0] cmd_color(input logic [3:0] k);
        cmd_color = (k < 4'd7) ? 3'(k + 4'd1) : 3'd0;
    endfunction

    function automatic logic [2:0] cmd_rate(input logic [3:0] k);
        case (k)
            4'd7: cmd_rate = 3'd6;
            4'd8: cmd_rate = 3'd1;
            4'd9: cmd_rate = 3'd2;
            4'd10: cmd_rate = 3'd3;
            4'd11: cmd_rate = 3'd4;
            4'd12: cmd_rate = 3'd5;
            default: cmd_rate = 3'd0;
        endcase
    endfunction

endpackage

/* hdl/clb_line_ram.sv */
// line buffer memory, one write and one registered read port
module clb_line_ram (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [clb_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [clb_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [clb_pkg::LINE_CAPACITY];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/clb_blink.sv */
// color, blink rate and tick counter state
module clb_blink (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_sw1,
    input  logic            i_sw2,
    input  logic            i_tick,
    input  clb_pkg::t_apply i_apply,
    output logic [3:0]      o_pins
);
    logic [2:0] r_color, n_color;
    logic [2:0] r_rate, n_rate;
    logic [9:0] r_half, n_half;
    logic [9:0] r_ms, n_ms;
    logic       r_lit, n_lit;
    logic [9:0] w_inc;

    // next blink state
    always_comb begin
        n_color = r_color;
        n_rate = r_rate;
        n_half = r_half;
        n_ms = r_ms;
        n_lit = r_lit;
        w_inc = r_ms + 10'd1;
        if (i_sw1) begin
            n_color = (r_color == 3'd7) ? 3'd1 : r_color + 3'd1;
        end
        if (i_sw2) begin
            n_rate = (r_rate >= 3'd6) ? 3'd1 : r_rate + 3'd1;
            n_half = clb_pkg::period_of(n_rate);
        end
        if (i_tick) begin
            if (r_color == 3'd0) begin
                n_ms = 10'd0;
                n_lit = 1'b1;
            end else if (w_inc >= r_half) begin
                n_ms = 10'd0;
                n_lit = ~r_lit;
            end else begin
                n_ms = w_inc;
            end
        end
        if (i_apply.set_color) begin
            n_color = i_apply.color;
        end
        if (i_apply.set_rate) begin
            n_rate = i_apply.rate;
            n_half = clb_pkg::period_of(i_apply.rate);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= 3'd0;
            r_rate <= 3'd0;
            r_half <= 10'd1000;
            r_ms <= 10'd0;
            r_lit <= 1'b1;
        end else begin
            r_color <= n_color;
            r_rate <= n_rate;
            r_half <= n_half;
            r_ms <= n_ms;
            r_lit <= n_lit;
        end
    end

    assign o_pins = r_lit ? clb_pkg::pin_of(r_color) : 4'h0;
endmodule

/* hdl/console_led_blink_controller_top.sv */
// top level of the console led blink controller
// Input channel i_in_* carries one item: cmd (char, switch one, switch two,
// tick) and char_code. Output channel o_out_* carries result items with a
// last flag; an item gives one to three results.
// One item is worked at a time. Ticks, switches and ordinary characters
// go from the idle state straight to the emit state, which gives the result; a
// backspace gives its three results on consecutive cycles when not stalled.
// Enter walks the line buffer through its single read port, one character
// a cycle, passing through the read state, the scan state and the decide
// state before the first result. Matching runs against all thirteen commands
// in parallel on the stripped text as it streams out of the memory.
// Reset clears the line length, the color (LED off), the blink rate and
// the tick counter; the buffer contents are left as they are.
// A stall on the output holds the current result; no new item is taken
// until the last result of the current one is transferred.
module console_led_blink_controller_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  clb_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output clb_pkg::t_out_item  o_out_data
);
    localparam int AW = clb_pkg::ADDR_W;
    localparam int LW = clb_pkg::LEN_W;

    clb_pkg::t_state r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_idx, n_idx;
    logic [3:0]    r_n, n_n;
    logic [12:0]   r_ok, n_ok;
    logic [1:0]    r_cnt, n_cnt;
    logic [1:0]    r_kind, n_kind;
    logic [7:0]    r_ch, n_ch;
    logic          r_bad, n_bad;
    logic          r_long, n_long;

    logic            w_acc, w_out_go;
    logic            w_we;
    logic [7:0]      w_low;
    logic [AW-1:0]   w_raddr;
    logic [7:0]      w_rdata;
    logic            w_sw1, w_sw2, w_tick;
    clb_pkg::t_apply w_apply;
    logic [3:0]      w_pins;
    logic [3:0]      w_hit;
    logic            w_any;
    logic [95:0]     w_txt;

    // kinds of work held for the emit step
    localparam logic [1:0] K_ONE = 2'd0;
    localparam logic [1:0] K_BS = 2'd1;
    localparam logic [1:0] K_ENT = 2'd2;

    assign w_acc = i_in_valid && !o_in_stall;
    assign w_out_go = o_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != clb_pkg::ST_IDLE);

    assign w_low = (i_in_data.char_code >= 8'h41 && i_in_data.char_code <= 8'h5A)
                 ? i_in_data.char_code + 8'h20 : i_in_data.char_code;
    assign w_we = w_acc && i_in_data.cmd == clb_pkg::CMD_CHAR
               && i_in_data.char_code != clb_pkg::CH_CR
               && !(i_in_data.char_code == clb_pkg::CH_BS && r_len != '0)
               && r_len < LW'(clb_pkg::LINE_CAPACITY);
    assign w_raddr = r_idx[AW-1:0];

    clb_line_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (w_low),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_sw1 = w_acc && i_in_data.cmd == clb_pkg::CMD_SW1;
    assign w_sw2 = w_acc && i_in_data.cmd == clb_pkg::CMD_SW2;
    assign w_tick = w_acc && i_in_data.cmd == clb_pkg::CMD_TICK;

    clb_blink u_blink (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sw1   (w_sw1),
        .i_sw2   (w_sw2),
        .i_tick  (w_tick),
        .i_apply (w_apply),
        .o_pins  (w_pins)
    );

    // pick the matched command
    always_comb begin
        w_hit = 4'd0;
        w_any = 1'b0;
        for (int k = clb_pkg::NUM_CMDS - 1; k >= 0; k--) begin
            if (r_ok[k] && r_n == clb_pkg::cmd_len(4'(k))) begin
                w_hit = 4'(k);
                w_any = 1'b1;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_len = r_len;
        n_idx = r_idx;
        n_n = r_n;
        n_ok = r_ok;
        n_cnt = r_cnt;
        n_kind = r_kind;
        n_ch = r_ch;
        n_bad = r_bad;
        n_long = r_long;
        w_apply = '0;
        w_txt = '0;
        o_out_valid = 1'b0;
        o_out_data = '0;
        o_out_data.led_pins = w_pins;
        case (r_state)
            clb_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_ch = i_in_data.char_code;
                    n_cnt = 2'd0;
                    n_bad = 1'b0;
                    n_state = clb_pkg::ST_EMIT;
                    n_kind = K_ONE;
                    if (i_in_data.cmd == clb_pkg::CMD_CHAR) begin
                        if (i_in_data.char_code == clb_pkg::CH_CR) begin
                            n_kind = K_ENT;
                            n_idx = '0;
                            n_n = 4'd0;
                            n_ok = '1;
                            n_long = 1'b0;
                            n_state = clb_pkg::ST_READ;
                        end else if (i_in_data.char_code == clb_pkg::CH_BS
                                     && r_len != '0) begin
                            n_kind = K_BS;
                            n_len = r_len - LW'(1);
                        end else if (w_we) begin
                            n_len = r_len + LW'(1);
                        end
                    end else begin
                        n_cnt = 2'd3;
                    end
                end
            end
            clb_pkg::ST_READ: begin
                if (r_idx >= r_len) begin
                    n_state = clb_pkg::ST_DECIDE;
                end else begin
                    n_idx = r_idx + LW'(1);
                    n_state = clb_pkg::ST_SCAN;
                end
            end
            clb_pkg::ST_SCAN: begin
                // compare one stripped character against every command
                if (!(w_rdata == 8'h20 || (w_rdata >= 8'h09 && w_rdata <= 8'h0D))) begin
                    if (r_n == 4'(clb_pkg::MAX_CMD_LEN)) begin
                        n_long = 1'b1;
                    end else begin
                        for (int k = 0; k < clb_pkg::NUM_CMDS; k++) begin
                            w_txt = clb_pkg::cmd_text(4'(k));
                            if (w_txt[95 - 8*r_n -: 8] != w_rdata) begin
                                n_ok[k] = 1'b0;
                            end
                        end
                        n_n = r_n + 4'd1;
                    end
                end
                if (r_idx >= r_len) begin
                    n_state = clb_pkg::ST_DECIDE;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end
            clb_pkg::ST_DECIDE: begin
                if (w_any && !r_long) begin
                    w_apply.set_color = (clb_pkg::cmd_color(w_hit) != 3'd0);
                    w_apply.color = clb_pkg::cmd_color(w_hit);
                    w_apply.set_rate = (clb_pkg::cmd_color(w_hit) == 3'd0);
                    w_apply.rate = clb_pkg::cmd_rate(w_hit);
                end
                n_bad = !(w_any && !r_long);
                n_len = '0;
                n_state = clb_pkg::ST_EMIT;
            end
            clb_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                o_out_data.tx_valid = 1'b1;
                case (r_kind)
                    K_ENT: begin
                        o_out_data.tx_char = (r_cnt == 2'd0) ? clb_pkg::CH_LF
                                                             : clb_pkg::CH_CR;
                        o_out_data.bad_command = (r_cnt == 2'd0) && r_bad;
                        o_out_data.last = (r_cnt == 2'd1);
                    end
                    K_BS: begin
                        o_out_data.tx_char = (r_cnt == 2'd1) ? clb_pkg::CH_SP
                                                             : clb_pkg::CH_BS;
                        o_out_data.last = (r_cnt == 2'd2);
                    end
                    default: begin
                        o_out_data.tx_valid = (r_cnt != 2'd3);
                        o_out_data.tx_char = (r_cnt != 2'd3) ? r_ch : 8'h00;
                        o_out_data.last = 1'b1;
                    end
                endcase
                if (w_out_go) begin
                    n_cnt = r_cnt + 2'd1;
                    if (o_out_data.last) begin
                        n_state = clb_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = clb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clb_pkg::ST_IDLE;
            r_len <= '0;
        end else begin
            r_state <= n_state;
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_n <= n_n;
        r_ok <= n_ok;
        r_cnt <= n_cnt;
        r_kind <= n_kind;
        r_ch <= n_ch;
        r_bad <= n_bad;
        r_long <= n_long;
    end
endmodule

/* hdl/clb_checker.sv */
// port-level checks for the console led blink controller
module clb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input clb_pkg::t_out_item o_out_data
);
    // no input taken while a result is pending
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input taken while result pending");

    // bad command only on a line feed result
    a_bad_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_command) |-> (o_out_data.tx_char == 8'h0A))
        else $error("bad command on wrong result");

    // line feed of enter is followed by carriage return
    a_lf_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.tx_char == 8'h0A && !o_out_data.last
         && o_out_data.tx_valid)
        |=> (o_out_valid && o_out_data.tx_char == 8'h0D)) else $error("missing cr");

    // stalled result stays valid with the same character
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data.tx_char)))
        else $error("stalled result changed");
endmodule

bind console_led_blink_controller_top clb_checker u_clb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
